// ===== rtl/core/ffud_pkg.sv =====
package ffud_pkg;

   localparam int SSID_SIZE_DEF = 32;
   localparam int PASS_SIZE_DEF = 64;

   localparam int KEY_BYTES = 9;
   localparam int KEY_SSID_LEN = 5;
   localparam int KEY_PASS_LEN = 9;

   // keys, first character in the lowest byte
   localparam logic [8*KEY_BYTES-1:0] KEY_SSID = {8'h00, 8'h00, 8'h00, 8'h00,
                                                 "=", "d", "i", "s", "s"};
   localparam logic [8*KEY_BYTES-1:0] KEY_PASS = {"=", "d", "r", "o", "w",
                                                 "s", "s", "a", "p"};

   localparam logic [7:0] CHAR_PCT = 8'h25;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_AMP = 8'h26;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   localparam int NUM_SLOTS = 5;

   typedef enum logic [1:0] {
      TAG_SSID = 2'd0,
      TAG_PASS = 2'd1,
      TAG_END  = 2'd2
   } tag_type;

   typedef struct packed {
      tag_type    tag;
      logic [7:0] data;
      logic       present;
   } res_type;

   typedef struct packed {
      logic [1:0] valid;
      logic [7:0] data0;
      logic [7:0] data1;
      logic       first_nz;
   } fld_res_type;

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= "0" && c <= "9") begin
         r = {1'b1, 4'(c - "0")};
      end else if (c >= "a" && c <= "f") begin
         r = {1'b1, 4'(c - "a" + 8'd10)};
      end else if (c >= "A" && c <= "F") begin
         r = {1'b1, 4'(c - "A" + 8'd10)};
      end
      return r;
   endfunction

   function automatic logic [7:0] hex_val(input logic [7:0] c1, input logic [7:0] c2);
      logic [4:0] h1;
      logic [4:0] h2;
      logic [7:0] r;
      h1 = hex_digit(c1);
      h2 = hex_digit(c2);
      r = 8'd0;
      if (h1[4]) begin
         r = h2[4] ? {h1[3:0], h2[3:0]} : {4'd0, h1[3:0]};
      end
      return r;
   endfunction

   function automatic logic [7:0] plain_char(input logic [7:0] c);
      return (c == CHAR_PLUS) ? CHAR_SPACE : c;
   endfunction

   // matched key length after byte c, with fallback along the key's borders
   function automatic logic [3:0] key_next(input logic [8*KEY_BYTES-1:0] key,
                                           input logic [3:0] p,
                                           input logic [7:0] c);
      logic [3:0] r;
      logic       ok;
      int         idx;
      r = 4'd0;
      for (int k = 1; k < KEY_BYTES; k++) begin
         if (k <= int'(p) && key[8*(k-1) +: 8] == c) begin
            ok = 1'b1;
            for (int j = 0; j < KEY_BYTES - 2; j++) begin
               if (j < k - 1) begin
                  idx = int'(p) - k + 1 + j;
                  if (key[8*idx +: 8] != key[8*j +: 8]) begin
                     ok = 1'b0;
                  end
               end
            end
            if (ok) begin
               r = 4'(k);
            end
         end
      end
      if (key[8*p +: 8] == c) begin
         r = p + 4'd1;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/form_field_url_decoder.sv =====
// Form field extractor: takes a url-encoded form body one byte per transaction
// (req_tlast on the final byte) and returns the percent-decoded bytes of the
// first ssid= and password= values, tagged in rsp_tuser (0 ssid, 1 password),
// then one summary transaction (tag 2) on the last body byte whose ssid_present
// bit tells whether the first ssid byte is nonzero. The results of one body
// byte come out in order ssid, password, summary, with rsp_tlast on the final
// one. Its results drain from a five-entry result buffer one per cycle while
// rsp_tready is high, so a byte that yields at most one result allows one byte
// per cycle while the output is not stalled, and the next body byte is taken
// only once the buffer is empty or its last result is being taken.
module form_field_url_decoder #(
   parameter int SSID_SIZE = ffud_pkg::SSID_SIZE_DEF,
   parameter int PASS_SIZE = ffud_pkg::PASS_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] body_byte
   input  logic        req_tlast,   // body_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] decoded_byte, [8] ssid_present
   output logic [1:0]  rsp_tuser,   // [1:0] field_tag
   output logic        rsp_tlast    // run_last
);
   import ffud_pkg::*;

   logic        accept;
   logic        free;
   fld_res_type ssid_res;
   fld_res_type pass_res;
   logic        nonempty_ff;
   logic [4:0]  load_valid;
   res_type     load_res [5];

   assign req_tready = free;
   assign accept = req_tvalid && free;

   ffud_field #(
      .KEY     (KEY_SSID),
      .KEY_LEN (KEY_SSID_LEN),
      .MAX     (SSID_SIZE)
   ) u_ssid (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .body_byte (req_tdata),
      .body_last (req_tlast),
      .res       (ssid_res)
   );

   ffud_field #(
      .KEY     (KEY_PASS),
      .KEY_LEN (KEY_PASS_LEN),
      .MAX     (PASS_SIZE)
   ) u_pass (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .body_byte (req_tdata),
      .body_last (req_tlast),
      .res       (pass_res)
   );

   assign load_valid = {req_tlast, pass_res.valid, ssid_res.valid};
   assign load_res[0] = '{tag: TAG_SSID, data: ssid_res.data0, present: 1'b0};
   assign load_res[1] = '{tag: TAG_SSID, data: ssid_res.data1, present: 1'b0};
   assign load_res[2] = '{tag: TAG_PASS, data: pass_res.data0, present: 1'b0};
   assign load_res[3] = '{tag: TAG_PASS, data: pass_res.data1, present: 1'b0};
   assign load_res[4] = '{tag: TAG_END, data: CHAR_NUL,
                          present: nonempty_ff || ssid_res.first_nz};

   always_ff @(posedge clock) begin
      if (reset || (accept && req_tlast)) begin
         nonempty_ff <= 1'b0;
      end else if (accept && ssid_res.first_nz) begin
         nonempty_ff <= 1'b1;
      end
   end

   ffud_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .load_valid (load_valid),
      .load_res   (load_res),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/core/ffud_field.sv =====
module ffud_field #(
   parameter logic [71:0] KEY     = 72'd0,
   parameter int          KEY_LEN = 5,
   parameter int          MAX     = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           body_byte,
   input  logic                 body_last,
   output ffud_pkg::fld_res_type res
);
   import ffud_pkg::*;

   localparam int CAP = MAX - 1;
   localparam int RAW_CAP = 3 * MAX - 1;
   localparam int PW = $clog2(KEY_LEN);
   localparam int OW = $clog2(MAX);
   localparam int RW = $clog2(3 * MAX);

   typedef enum logic [1:0] {
      PH_SEARCH = 2'd0,
      PH_VALUE  = 2'd1,
      PH_DONE   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      PEND_NONE = 2'd0,
      PEND_PCT  = 2'd1,
      PEND_BYTE = 2'd2
   } pend_type;

   phase_type   phase_ff, phase_in;
   pend_type    pcnt_ff, pcnt_in;
   logic [7:0]  held_ff, held_in;
   logic [PW-1:0] prog_ff, prog_in;
   logic [RW-1:0] raw_ff, raw_in;
   logic [OW-1:0] oc_ff, oc_in;
   logic [1:0]  ncand;
   logic [7:0]  c0;
   logic [7:0]  c1;
   logic [3:0]  nxt;
   logic        endnow;
   logic        v0;
   logic        v1;

   assign endnow = (raw_ff == RW'(RAW_CAP - 1)) || body_last;

   always_comb begin
      phase_in = phase_ff;
      pcnt_in = pcnt_ff;
      held_in = held_ff;
      prog_in = prog_ff;
      raw_in = raw_ff;
      ncand = 2'd0;
      c0 = CHAR_NUL;
      c1 = CHAR_NUL;
      nxt = 4'd0;
      unique case (phase_ff)
         PH_SEARCH: begin
            if (body_byte == CHAR_NUL) begin
               phase_in = PH_DONE;
            end else begin
               nxt = key_next(KEY, 4'(prog_ff), body_byte);
               if (nxt == 4'(KEY_LEN)) begin
                  prog_in = '0;
                  phase_in = PH_VALUE;
               end else begin
                  prog_in = PW'(nxt);
               end
            end
         end
         PH_VALUE: begin
            if (body_byte == CHAR_AMP || body_byte == CHAR_NUL) begin
               if (pcnt_ff == PEND_PCT) begin
                  ncand = 2'd1;
                  c0 = CHAR_PCT;
               end else if (pcnt_ff == PEND_BYTE) begin
                  ncand = 2'd2;
                  c0 = CHAR_PCT;
                  c1 = plain_char(held_ff);
               end
               pcnt_in = PEND_NONE;
               phase_in = PH_DONE;
            end else begin
               raw_in = raw_ff + RW'(1);
               case (pcnt_ff)
                  PEND_PCT: begin
                     pcnt_in = PEND_BYTE;
                     held_in = body_byte;
                     if (endnow) begin
                        ncand = 2'd2;
                        c0 = CHAR_PCT;
                        c1 = plain_char(body_byte);
                     end
                  end
                  PEND_BYTE: begin
                     ncand = 2'd1;
                     c0 = hex_val(held_ff, body_byte);
                     pcnt_in = PEND_NONE;
                  end
                  default: begin
                     if (body_byte == CHAR_PCT) begin
                        pcnt_in = PEND_PCT;
                        if (endnow) begin
                           ncand = 2'd1;
                           c0 = CHAR_PCT;
                        end
                     end else begin
                        ncand = 2'd1;
                        c0 = plain_char(body_byte);
                     end
                  end
               endcase
               if (endnow) begin
                  phase_in = PH_DONE;
                  pcnt_in = PEND_NONE;
               end
            end
         end
         default: ;
      endcase
   end

   // drop decoded bytes past the output cap
   assign v0 = (ncand != 2'd0) && (oc_ff != OW'(CAP));
   assign v1 = (ncand == 2'd2) && v0 && (oc_ff != OW'(CAP - 1));
   assign oc_in = oc_ff + OW'(v0) + OW'(v1);

   assign res.valid = {v1, v0};
   assign res.data0 = c0;
   assign res.data1 = c1;
   assign res.first_nz = v0 && (oc_ff == '0) && (c0 != CHAR_NUL);

   always_ff @(posedge clock) begin
      if (reset || (step && body_last)) begin
         phase_ff <= PH_SEARCH;
         pcnt_ff <= PEND_NONE;
         prog_ff <= '0;
         raw_ff <= '0;
         oc_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         pcnt_ff <= pcnt_in;
         prog_ff <= prog_in;
         raw_ff <= raw_in;
         oc_ff <= oc_in;
      end
      if (step) begin
         held_ff <= held_in;
      end
   end

endmodule

// ===== rtl/core/ffud_out.sv =====
module ffud_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [4:0]          load_valid,
   input  ffud_pkg::res_type   load_res [5],
   output logic                free,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,   // [7:0] decoded_byte, [8] ssid_present
   output logic [1:0]          rsp_tuser,   // [1:0] field_tag
   output logic                rsp_tlast    // run_last
);
   import ffud_pkg::*;

   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   res_type              slot_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] head;
   res_type              cur;
   logic                 taken;
   logic                 single;

   always_comb begin
      head = '0;
      cur = slot_ff[0];
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i]) begin
            head = NUM_SLOTS'(1) << i;
            cur = slot_ff[i];
         end
      end
   end

   assign single = ($countones(valid_ff) == 1);
   assign taken = rsp_tvalid && rsp_tready;
   assign free = (valid_ff == '0) || (single && rsp_tready);

   always_comb begin
      if (load) begin
         valid_in = load_valid;
      end else if (taken) begin
         valid_in = valid_ff & ~head;
      end else begin
         valid_in = valid_ff;
      end
   end

   assign rsp_tvalid = (valid_ff != '0);
   assign rsp_tdata = {7'd0, cur.present, cur.data};
   assign rsp_tuser = cur.tag;
   assign rsp_tlast = single;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_ff[i] <= load_res[i];
         end
      end
   end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
   import ffud_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_ITEMS = 100;
   localparam int SSID_LONG = 100;
   localparam int PASS_LONG = 130;

   typedef enum logic [1:0] {
      PH_SEARCH,
      PH_VALUE,
      PH_DONE
   } phase_type;

   typedef struct {
      tag_type    tag;
      logic [7:0] data;
      logic       present;
      logic       run_last;
   } decoded_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   decoded_type decoded_q[$];
   int          errors = 0;
   int          cycles = 0;
   int          sent = 0;
   int          src_mode = 0;
   int          sink_mode = 0;

   int          key_pos[2];
   phase_type   fld_phase[2];
   int          raw_cnt[2];
   int          out_cnt[2];
   int          hold_cnt[2];
   logic [7:0]  hold_byte[2];
   logic        ssid_nonzero;

   form_field_url_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("** form_field_url_decoder: FAILED **");
         $finish;
      end
   end

   function automatic logic [7:0] key_char(input int f, input int i);
      return (f == 0) ? KEY_SSID[8*i +: 8] : KEY_PASS[8*i +: 8];
   endfunction

   function automatic int key_len(input int f);
      return (f == 0) ? KEY_SSID_LEN : KEY_PASS_LEN;
   endfunction

   function automatic int field_max(input int f);
      return (f == 0) ? SSID_SIZE_DEF : PASS_SIZE_DEF;
   endfunction

   function automatic void clear_fields();
      for (int f = 0; f < 2; f++) begin
         key_pos[f] = 0;
         fld_phase[f] = PH_SEARCH;
         raw_cnt[f] = 0;
         out_cnt[f] = 0;
         hold_cnt[f] = 0;
         hold_byte[f] = 8'd0;
      end
      ssid_nonzero = 1'b0;
   endfunction

   // longest key prefix that ends at byte c, falling back along the key's borders
   function automatic int match_len(input int f, input int p, input logic [7:0] c);
      bit ok;
      if (c == key_char(f, p)) return p + 1;
      for (int k = p; k >= 1; k--) begin
         if (key_char(f, k - 1) == c) begin
            ok = 1'b1;
            for (int j = 0; j < k - 1; j++) begin
               if (key_char(f, j) != key_char(f, p - k + 1 + j)) ok = 1'b0;
            end
            if (ok) return k;
         end
      end
      return 0;
   endfunction

   function automatic int nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   function automatic logic [7:0] unplus(input logic [7:0] c);
      return (c == CHAR_PLUS) ? CHAR_SPACE : c;
   endfunction

   function automatic void push_decoded(input int f, input logic [7:0] b);
      decoded_type d;
      if (out_cnt[f] >= field_max(f) - 1) return;
      if (f == 0 && out_cnt[f] == 0 && b != 8'd0) ssid_nonzero = 1'b1;
      out_cnt[f]++;
      d.tag = tag_type'(f);
      d.data = b;
      d.present = 1'b0;
      d.run_last = 1'b0;
      decoded_q.push_back(d);
   endfunction

   function automatic void flush_hold(input int f);
      if (hold_cnt[f] >= 1) push_decoded(f, CHAR_PCT);
      if (hold_cnt[f] >= 2) push_decoded(f, unplus(hold_byte[f]));
      hold_cnt[f] = 0;
   endfunction

   function automatic void decode_field(input int f, input logic [7:0] b, input logic lst);
      int h1;
      int h2;
      logic [7:0] v;
      if (fld_phase[f] == PH_SEARCH) begin
         if (b == CHAR_NUL) begin
            fld_phase[f] = PH_DONE;
         end else begin
            key_pos[f] = match_len(f, key_pos[f], b);
            if (key_pos[f] >= key_len(f)) begin
               key_pos[f] = 0;
               fld_phase[f] = PH_VALUE;
            end
         end
         return;
      end
      if (fld_phase[f] != PH_VALUE) return;
      if (b == CHAR_AMP || b == CHAR_NUL) begin
         flush_hold(f);
         fld_phase[f] = PH_DONE;
         return;
      end
      raw_cnt[f]++;
      if (hold_cnt[f] == 0) begin
         if (b == CHAR_PCT) hold_cnt[f] = 1;
         else push_decoded(f, unplus(b));
      end else if (hold_cnt[f] == 1) begin
         hold_cnt[f] = 2;
         hold_byte[f] = b;
      end else begin
         h1 = nibble(hold_byte[f]);
         h2 = nibble(b);
         v = 8'd0;
         if (h1 >= 0) v = (h2 >= 0) ? 8'(h1 * 16 + h2) : 8'(h1);
         hold_cnt[f] = 0;
         push_decoded(f, v);
      end
      if (raw_cnt[f] >= 3 * field_max(f) - 1 || lst) begin
         flush_hold(f);
         fld_phase[f] = PH_DONE;
      end
   endfunction

   function automatic void decode_body_byte(input logic [7:0] b, input logic lst);
      int before_n;
      decoded_type d;
      before_n = decoded_q.size();
      decode_field(0, b, lst);
      decode_field(1, b, lst);
      if (lst) begin
         d.tag = TAG_END;
         d.data = 8'd0;
         d.present = ssid_nonzero;
         d.run_last = 1'b0;
         decoded_q.push_back(d);
         clear_fields();
      end
      if (decoded_q.size() > before_n) begin
         d = decoded_q.pop_back();
         d.run_last = 1'b1;
         decoded_q.push_back(d);
      end
   endfunction

   function automatic int draw_wait(input int mode);
      case (mode)
         0: return 0;
         1: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
         default: return $urandom_range(0, 18);
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic lst);
      int gap;
      gap = draw_wait(src_mode);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= lst;
      do @(posedge clock); while (!req_tready);
      decode_body_byte(b, lst);
      sent++;
   endtask

   task automatic send_text(input string s, input logic end_body);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], end_body && (i == s.len() - 1));
      end
   endtask

   task automatic send_body(ref logic [7:0] body[$]);
      for (int i = 0; i < body.size(); i++) begin
         send_byte(body[i], i == body.size() - 1);
      end
   endtask

   // drop the input and hold until every expected result has come
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (decoded_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick(input string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   // never '&' or zero; those end a value and are placed by the body builder
   function automatic logic [7:0] value_char();
      logic [7:0] r;
      case ($urandom_range(0, 9))
         0, 1, 2: r = pick("abxyzXYZ019sp=");
         3, 4: r = CHAR_PCT;
         5, 6: r = pick("0123456789abcdefABCDEF");
         7: r = CHAR_PLUS;
         8: r = pick("gGz:/ ");
         default: r = 8'($urandom_range(1, 255));
      endcase
      if (r == CHAR_AMP) r = 8'hFF;
      return r;
   endfunction

   function automatic void append_text(ref logic [7:0] body[$], input string s);
      for (int i = 0; i < s.len(); i++) body.push_back(s[i]);
   endfunction

   function automatic void build_body(ref logic [7:0] body[$]);
      int nseg;
      int kind;
      int len;
      body.delete();
      nseg = $urandom_range(1, 4);
      for (int s = 0; s < nseg; s++) begin
         kind = $urandom_range(0, 11);
         if (kind < 4) append_text(body, "ssid=");
         else if (kind < 8) append_text(body, "password=");
         else if (kind == 8) append_text(body, "k=");
         if (kind >= 9) begin
            len = $urandom_range(1, 8);
            repeat (len) begin
               if ($urandom_range(0, 15) == 0) body.push_back(CHAR_NUL);
               else body.push_back(pick("sspasswordid=xX"));
            end
         end else begin
            len = $urandom_range(0, 12);
            repeat (len) body.push_back(value_char());
         end
         if ($urandom_range(0, 4) != 0) body.push_back(CHAR_AMP);
      end
      if (body.size() == 0) body.push_back(value_char());
   endfunction

   task automatic test_escapes();
      src_mode = 0;
      sink_mode = 1;
      send_text("ssid=%00%Ff%az%g+%+", 1'b1);
   endtask

   task automatic test_zero_byte();
      src_mode = 2;
      sink_mode = 2;
      send_text("ssid=x", 1'b0);
      send_byte(CHAR_NUL, 1'b0);
      wait_drained();
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_caps();
      logic [7:0] body[$];
      src_mode = 1;
      sink_mode = 1;
      append_text(body, "ssid=");
      repeat (SSID_LONG) body.push_back(value_char());
      append_text(body, "&password=");
      repeat (PASS_LONG) body.push_back(value_char());
      send_body(body);
   endtask

   task automatic test_random_bodies();
      logic [7:0] body[$];
      int stop_at;
      stop_at = sent + RANDOM_ITEMS;
      while (sent < stop_at) begin
         src_mode = $urandom_range(0, 2);
         sink_mode = $urandom_range(0, 2);
         build_body(body);
         send_body(body);
         if ($urandom_range(0, 7) == 0) wait_drained();
      end
   endtask

   initial begin : sink
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         stall = draw_wait(sink_mode);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin : check
      decoded_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (decoded_q.size() == 0) begin
            $display("%0t: unexpected result tag %0d data %h last %b", $time,
                     rsp_tuser, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = decoded_q.pop_front();
            if (rsp_tuser !== want.tag) begin
               $display("%0t: tag expected %0d actual %0d", $time, want.tag, rsp_tuser);
               errors++;
            end
            if (rsp_tdata !== {7'd0, want.present, want.data}) begin
               $display("%0t: tdata expected %h actual %h", $time,
                        {7'd0, want.present, want.data}, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== want.run_last) begin
               $display("%0t: tlast expected %b actual %b", $time, want.run_last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   initial begin
      clear_fields();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_escapes();
      test_zero_byte();
      test_caps();
      test_random_bodies();
      wait_drained();
      repeat (40) @(posedge clock);
      if (decoded_q.size() != 0) errors++;
      if (errors == 0) begin
         $display("** form_field_url_decoder: PASSED **");
      end else begin
         $display("** form_field_url_decoder: FAILED **");
      end
      $finish;
   end

endmodule

// ===== form_field_url_decoder.f =====
rtl/core/ffud_pkg.sv
rtl/core/ffud_field.sv
rtl/core/ffud_out.sv
rtl/core/form_field_url_decoder.sv
dv/tb_top.sv
